@@ src/jpvg_pkg.sv @@
package jpvg_pkg;

   localparam int MAX_VERSION_BYTES_DEFAULT = 23;
   localparam int TARGET_BYTES = 23;

   localparam logic [7:0] HEADER_BYTES = 8'd4;
   localparam logic [7:0] FIXED_BYTES = 8'd5;

   localparam logic [1:0] CSR_TARGET_LENGTH = 2'd0;
   localparam logic [1:0] CSR_TARGET_LOW = 2'd1;
   localparam logic [1:0] CSR_TARGET_MIDDLE = 2'd2;
   localparam logic [1:0] CSR_TARGET_HIGH = 2'd3;

   localparam logic [1:0] VERDICT_COMPATIBLE = 2'd0;
   localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_NAME_LEN = 3'd1,
      PH_NAME_BODY = 3'd2,
      PH_SKIN_LEN = 3'd3,
      PH_SKIN_BODY = 3'd4,
      PH_FIXED = 3'd5,
      PH_VER_LEN = 3'd6,
      PH_VER_BODY = 3'd7
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [4:0] peer_version_length;
   } rsp_payload_type;

endpackage

@@ src/join_payload_version_gate.sv @@
// Join payload version gate. Takes a join payload one byte per request, the final byte
// marked by last_byte, and returns one verdict per payload: compatible, malformed or
// version mismatch, together with the peer's version length. A byte is taken in every
// cycle while req_ready is high. Verdicts sit in an output register backed by one skid
// entry, so req_ready only drops while both hold a result the consumer has not taken.
// Target string and length must be written through the csr port while no payload is in
// flight; the block itself does not enforce this.
module join_payload_version_gate
   import jpvg_pkg::*;
#(
   parameter int MAX_VERSION_BYTES = MAX_VERSION_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [63:0]     csr_wdata
);

   logic [4:0]  target_length_ff;
   logic [63:0] target_low_ff;
   logic [63:0] target_middle_ff;
   logic [55:0] target_high_ff;

   parse_phase_type phase_ff, phase_in, phase_step;
   logic [7:0] bytes_left_ff, bytes_left_in, bytes_left_step, bytes_left_dec;
   logic [4:0] version_index_ff, version_index_in, version_index_step;
   logic [4:0] peer_length_ff, peer_length_in, peer_length_step;
   logic       matching_ff, matching_in, matching_step;
   logic       too_long_ff, too_long_in, too_long_step;

   logic [183:0] target_all;
   logic [7:0]   target_byte;

   logic            accept;
   logic            produce;
   logic            complete;
   rsp_payload_type result;

   rsp_payload_type out_ff, out_in, skid_ff, skid_in;
   logic            out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   assign accept = req_valid && req_ready;
   assign produce = accept && req_payload.last_byte;
   assign req_ready = !skid_valid_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         target_length_ff <= '0;
         target_low_ff <= '0;
         target_middle_ff <= '0;
         target_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TARGET_LENGTH: target_length_ff <= csr_wdata[4:0];
            CSR_TARGET_LOW:    target_low_ff <= csr_wdata;
            CSR_TARGET_MIDDLE: target_middle_ff <= csr_wdata;
            CSR_TARGET_HIGH:   target_high_ff <= csr_wdata[55:0];
            default:           target_low_ff <= target_low_ff;
         endcase
      end
   end

   assign target_all = {target_high_ff, target_middle_ff, target_low_ff};

   always_comb begin
      if (version_index_ff < 5'(TARGET_BYTES)) begin
         target_byte = target_all[{version_index_ff, 3'b000} +: 8];
      end else begin
         target_byte = 8'd0;
      end
   end

   assign bytes_left_dec = (bytes_left_ff != 8'd0) ? bytes_left_ff - 8'd1 : bytes_left_ff;

   // parser next state
   always_comb begin
      phase_step = phase_ff;
      bytes_left_step = bytes_left_ff;
      version_index_step = version_index_ff;
      peer_length_step = peer_length_ff;
      matching_step = matching_ff;
      too_long_step = too_long_ff;
      case (phase_ff)
         PH_HEADER, PH_FIXED: begin
            bytes_left_step = bytes_left_dec;
            if (bytes_left_dec == 8'd0) begin
               phase_step = (phase_ff == PH_HEADER) ? PH_NAME_LEN : PH_VER_LEN;
            end
         end
         PH_NAME_LEN, PH_SKIN_LEN: begin
            if (req_payload.data_byte == 8'd0) begin
               phase_step = (phase_ff == PH_NAME_LEN) ? PH_SKIN_LEN : PH_FIXED;
               bytes_left_step = (phase_ff == PH_NAME_LEN) ? 8'd0 : FIXED_BYTES;
            end else begin
               phase_step = (phase_ff == PH_NAME_LEN) ? PH_NAME_BODY : PH_SKIN_BODY;
               bytes_left_step = req_payload.data_byte;
            end
         end
         PH_NAME_BODY, PH_SKIN_BODY: begin
            bytes_left_step = bytes_left_dec;
            if (bytes_left_dec == 8'd0) begin
               phase_step = (phase_ff == PH_NAME_BODY) ? PH_SKIN_LEN : PH_FIXED;
               bytes_left_step = (phase_ff == PH_NAME_BODY) ? 8'd0 : FIXED_BYTES;
            end
         end
         PH_VER_LEN: begin
            phase_step = PH_VER_BODY;
            version_index_step = '0;
            if (req_payload.data_byte > 8'(MAX_VERSION_BYTES)) begin
               too_long_step = 1'b1;
               bytes_left_step = 8'd0;
               peer_length_step = '0;
            end else begin
               peer_length_step = req_payload.data_byte[4:0];
               bytes_left_step = req_payload.data_byte;
               matching_step = (req_payload.data_byte == {3'b000, target_length_ff});
            end
         end
         PH_VER_BODY: begin
            if (bytes_left_ff != 8'd0 && !too_long_ff) begin
               if (req_payload.data_byte != target_byte) begin
                  matching_step = 1'b0;
               end
               version_index_step = version_index_ff + 5'd1;
               bytes_left_step = bytes_left_dec;
            end
         end
         default: phase_step = PH_HEADER;
      endcase

      phase_in = phase_ff;
      bytes_left_in = bytes_left_ff;
      version_index_in = version_index_ff;
      peer_length_in = peer_length_ff;
      matching_in = matching_ff;
      too_long_in = too_long_ff;
      if (accept) begin
         if (req_payload.last_byte) begin
            phase_in = PH_HEADER;
            bytes_left_in = HEADER_BYTES;
            version_index_in = '0;
            peer_length_in = '0;
            matching_in = 1'b1;
            too_long_in = 1'b0;
         end else begin
            phase_in = phase_step;
            bytes_left_in = bytes_left_step;
            version_index_in = version_index_step;
            peer_length_in = peer_length_step;
            matching_in = matching_step;
            too_long_in = too_long_step;
         end
      end
   end

   // verdict
   always_comb begin
      complete = (phase_step == PH_VER_BODY) && (bytes_left_step == 8'd0) && !too_long_step;
      if (!complete) begin
         result.verdict = VERDICT_MALFORMED;
         result.peer_version_length = '0;
      end else begin
         result.verdict = matching_step ? VERDICT_COMPATIBLE : VERDICT_MISMATCH;
         result.peer_version_length = peer_length_step;
      end
   end

   // output register with one skid entry
   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in = result;
            out_valid_in = produce;
         end
      end else if (produce) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         bytes_left_ff <= HEADER_BYTES;
         version_index_ff <= '0;
         peer_length_ff <= '0;
         matching_ff <= 1'b1;
         too_long_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         bytes_left_ff <= bytes_left_in;
         version_index_ff <= version_index_in;
         peer_length_ff <= peer_length_in;
         matching_ff <= matching_in;
         too_long_ff <= too_long_in;
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output result");

   a_parser_restarts: assert property (@(posedge clock) disable iff (reset)
      produce |=> (phase_ff == PH_HEADER) && (bytes_left_ff == HEADER_BYTES) && !too_long_ff)
      else $error("parser not cleared after final byte");

   a_malformed_length_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.verdict == VERDICT_MALFORMED) |-> out_ff.peer_version_length == '0)
      else $error("malformed verdict with nonzero length");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.verdict == VERDICT_COMPATIBLE) ||
                       (out_ff.verdict == VERDICT_MALFORMED) ||
                       (out_ff.verdict == VERDICT_MISMATCH))
      else $error("undefined verdict code");

endmodule
